/* rtl/huff_pkg.sv */
// shared constants, types and command bundle for the huffman code builder
// no dependencies; used by huff_ctrl, huff_dpath and huffman_code_builder
package huff_pkg;

   localparam int NUM_SYMBOLS   = 27;
   localparam int WEIGHT_BITS   = 16;

   localparam int NODE_COUNT    = 2 * NUM_SYMBOLS - 1;
   localparam int MERGE_COUNT   = NUM_SYMBOLS - 1;
   localparam int SYM_IDX_BITS  = $clog2(NUM_SYMBOLS);
   localparam int MRG_IDX_BITS  = (MERGE_COUNT > 1) ? $clog2(MERGE_COUNT) : 1;
   localparam int NODE_ID_BITS  = $clog2(NODE_COUNT);
   localparam int NODE_W_BITS   = WEIGHT_BITS + SYM_IDX_BITS;

   localparam int IN_WEIGHT_BITS = 16;
   localparam int IN_USE_BITS    = (WEIGHT_BITS < IN_WEIGHT_BITS) ? WEIGHT_BITS : IN_WEIGHT_BITS;
   localparam int INDEX_BITS     = 5;
   localparam int LEN_BITS       = 5;
   localparam int CODE_BITS      = 26;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_POP,
      ST_INSERT,
      ST_CODE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                    insert_leaf;
      logic                    pop;
      logic                    insert_node;
      logic                    clear;
      logic                    code_step;
      logic                    emit;
      logic [SYM_IDX_BITS-1:0] index;
   } cmd_type;

endpackage

/* rtl/huffman_code_builder.sv */
// top level of the huffman code builder: ties the sequencer to the datapath
// depends on huff_pkg, huff_ctrl, huff_dpath
// weights load one per cycle while busy is low and start is high; the final weight of a set starts
// the build: NUM_SYMBOLS-1 merges (a pop then an insert each), a code walk over the merges from
// the root down, and then one emit per symbol; each result beat is registered after its emit
// NUM_SYMBOLS beats follow one per cycle; busy stays high from the first merge to the last emit;
// reset (synchronous) empties the list, and the next weight loads as symbol 0
module huffman_code_builder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [huff_pkg::IN_WEIGHT_BITS-1:0] req_symbol_weight,
   output logic                                rsp_strobe,
   output logic [huff_pkg::INDEX_BITS-1:0]     rsp_symbol_index,
   output logic [huff_pkg::LEN_BITS-1:0]       rsp_code_length,
   output logic [huff_pkg::CODE_BITS-1:0]      rsp_code_bits,
   output logic                                rsp_last_code
);

   huff_pkg::cmd_type cmd;

   huff_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   huff_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_symbol_weight (req_symbol_weight),
      .rsp_strobe        (rsp_strobe),
      .rsp_symbol_index  (rsp_symbol_index),
      .rsp_code_length   (rsp_code_length),
      .rsp_code_bits     (rsp_code_bits),
      .rsp_last_code     (rsp_last_code)
   );

endmodule

/* rtl/huff_ctrl.sv */
// sequencer for the huffman code builder: load, merge, code walk, emit
// depends on huff_pkg
module huff_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output huff_pkg::cmd_type cmd
);

   localparam logic [huff_pkg::SYM_IDX_BITS-1:0] LAST_SYM =
      huff_pkg::SYM_IDX_BITS'(huff_pkg::NUM_SYMBOLS - 1);
   localparam logic [huff_pkg::SYM_IDX_BITS-1:0] LAST_MRG =
      huff_pkg::SYM_IDX_BITS'(huff_pkg::MERGE_COUNT - 1);

   huff_pkg::state_type state_ff, state_in;
   logic [huff_pkg::SYM_IDX_BITS-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= huff_pkg::ST_LOAD;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         huff_pkg::ST_LOAD: begin
            if (start) begin
               if (cnt_ff == LAST_SYM) begin
                  state_in = huff_pkg::ST_POP;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         huff_pkg::ST_POP: begin
            state_in = huff_pkg::ST_INSERT;
         end
         huff_pkg::ST_INSERT: begin
            if (cnt_ff == LAST_MRG) begin
               state_in = huff_pkg::ST_CODE;
            end else begin
               state_in = huff_pkg::ST_POP;
               cnt_in   = cnt_ff + 1'b1;
            end
         end
         huff_pkg::ST_CODE: begin
            // walk merges from the root down
            if (cnt_ff == '0) begin
               state_in = huff_pkg::ST_EMIT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         huff_pkg::ST_EMIT: begin
            if (cnt_ff == LAST_SYM) begin
               state_in = huff_pkg::ST_LOAD;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = huff_pkg::ST_LOAD;
            cnt_in   = '0;
         end
      endcase
   end

   always_comb begin
      busy            = (state_ff != huff_pkg::ST_LOAD);
      cmd.insert_leaf = (state_ff == huff_pkg::ST_LOAD) && start;
      cmd.pop         = (state_ff == huff_pkg::ST_POP);
      cmd.insert_node = (state_ff == huff_pkg::ST_INSERT);
      cmd.clear       = (state_ff == huff_pkg::ST_CODE);
      cmd.code_step   = (state_ff == huff_pkg::ST_CODE);
      cmd.emit        = (state_ff == huff_pkg::ST_EMIT);
      cmd.index       = cnt_ff;
   end

   a_load_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == huff_pkg::ST_LOAD && start && cnt_ff == LAST_SYM)
         |=> state_ff == huff_pkg::ST_POP)
      else $error("full weight set did not start tree build");

   a_emit_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == huff_pkg::ST_EMIT && cnt_ff == LAST_SYM)
         |=> (state_ff == huff_pkg::ST_LOAD && cnt_ff == '0))
      else $error("emission did not return to load");

   a_merge_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == huff_pkg::ST_POP || state_ff == huff_pkg::ST_INSERT
         || state_ff == huff_pkg::ST_CODE) |-> cnt_ff <= LAST_MRG)
      else $error("merge counter out of range");

endmodule

/* rtl/huff_dpath.sv */
// datapath: sorted node list, child links, code/depth tables, result registers
// depends on huff_pkg
module huff_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  huff_pkg::cmd_type              cmd,
   input  logic [huff_pkg::IN_WEIGHT_BITS-1:0] req_symbol_weight,
   output logic                           rsp_strobe,
   output logic [huff_pkg::INDEX_BITS-1:0] rsp_symbol_index,
   output logic [huff_pkg::LEN_BITS-1:0]   rsp_code_length,
   output logic [huff_pkg::CODE_BITS-1:0]  rsp_code_bits,
   output logic                           rsp_last_code
);

   localparam int NS = huff_pkg::NUM_SYMBOLS;
   localparam int NM = huff_pkg::MERGE_COUNT;
   localparam int IB = huff_pkg::NODE_ID_BITS;
   localparam int WB = huff_pkg::NODE_W_BITS;
   localparam int MB = huff_pkg::MRG_IDX_BITS;
   localparam int SB = huff_pkg::SYM_IDX_BITS;
   localparam logic [IB-1:0] FIRST_MERGED = IB'(NS);

   // list holds live nodes lightest first; index 0 and 1 are the next pair
   logic [IB-1:0] ent_id_ff [NS];
   logic [WB-1:0] ent_w_ff  [NS];
   logic          ent_v_ff  [NS];
   logic [IB-1:0] ent_id_in [NS];
   logic [WB-1:0] ent_w_in  [NS];
   logic          ent_v_in  [NS];
   logic          lt        [NS];

   logic [IB-1:0] left_ff  [NM];
   logic [IB-1:0] right_ff [NM];
   logic [huff_pkg::LEN_BITS-1:0]  idep_ff  [NM];
   logic [huff_pkg::CODE_BITS-1:0] icode_ff [NM];
   logic [huff_pkg::LEN_BITS-1:0]  ldep_ff  [NS];
   logic [huff_pkg::CODE_BITS-1:0] lcode_ff [NS];

   logic [WB-1:0] sum_ff, sum_in;
   logic [IB-1:0] ins_id;
   logic [WB-1:0] ins_w;

   logic [MB-1:0] m_idx;
   logic          m_root;
   logic [huff_pkg::LEN_BITS-1:0]  par_dep, kid_dep;
   logic [huff_pkg::CODE_BITS-1:0] par_code, code0, code1;
   logic [IB-1:0] c0, c1, c0_int, c1_int;
   logic [SB-1:0] e_idx;

   logic                            strobe_ff;
   logic [huff_pkg::INDEX_BITS-1:0] sym_ff;
   logic [huff_pkg::LEN_BITS-1:0]   len_ff;
   logic [huff_pkg::CODE_BITS-1:0]  bits_ff;
   logic                            last_ff;

   always_comb begin
      if (cmd.insert_leaf) begin
         ins_id = IB'(cmd.index);
         ins_w  = WB'(req_symbol_weight[huff_pkg::IN_USE_BITS-1:0]);
      end else begin
         ins_id = FIRST_MERGED + IB'(cmd.index);
         ins_w  = sum_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < NS; i++) begin
         lt[i]        = ent_v_ff[i] && (ent_w_ff[i] < ins_w);
         ent_id_in[i] = ent_id_ff[i];
         ent_w_in[i]  = ent_w_ff[i];
         ent_v_in[i]  = ent_v_ff[i];
      end
      if (cmd.clear) begin
         for (int i = 0; i < NS; i++) begin
            ent_v_in[i] = 1'b0;
         end
      end else if (cmd.pop) begin
         for (int i = 0; i < NS; i++) begin
            if (i + 2 < NS) begin
               ent_id_in[i] = ent_id_ff[(i + 2 < NS) ? i + 2 : i];
               ent_w_in[i]  = ent_w_ff[(i + 2 < NS) ? i + 2 : i];
               ent_v_in[i]  = ent_v_ff[(i + 2 < NS) ? i + 2 : i];
            end else begin
               ent_v_in[i]  = 1'b0;
            end
         end
      end else if (cmd.insert_leaf || cmd.insert_node) begin
         // new node goes behind every strictly lighter one
         for (int i = 0; i < NS; i++) begin
            if (!lt[i]) begin
               if (i == 0 || lt[(i > 0) ? i - 1 : 0]) begin
                  ent_id_in[i] = ins_id;
                  ent_w_in[i]  = ins_w;
                  ent_v_in[i]  = 1'b1;
               end else begin
                  ent_id_in[i] = ent_id_ff[(i > 0) ? i - 1 : 0];
                  ent_w_in[i]  = ent_w_ff[(i > 0) ? i - 1 : 0];
                  ent_v_in[i]  = ent_v_ff[(i > 0) ? i - 1 : 0];
               end
            end
         end
      end
   end

   assign sum_in = ent_w_ff[0] + ent_w_ff[1];
   assign m_idx  = cmd.index[MB-1:0];
   assign m_root = (cmd.index == SB'(NM - 1));

   always_comb begin
      par_dep  = m_root ? '0 : idep_ff[m_idx];
      par_code = m_root ? '0 : icode_ff[m_idx];
      kid_dep  = par_dep + 1'b1;
      code0    = {par_code[huff_pkg::CODE_BITS-2:0], 1'b0};
      code1    = {par_code[huff_pkg::CODE_BITS-2:0], 1'b1};
      c0       = left_ff[m_idx];
      c1       = right_ff[m_idx];
      c0_int   = c0 - FIRST_MERGED;
      c1_int   = c1 - FIRST_MERGED;
   end

   assign e_idx = cmd.index;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) begin
            ent_v_ff[i] <= 1'b0;
         end
         strobe_ff <= 1'b0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            ent_v_ff[i] <= ent_v_in[i];
         end
         strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NS; i++) begin
         ent_id_ff[i] <= ent_id_in[i];
         ent_w_ff[i]  <= ent_w_in[i];
      end
      if (cmd.pop) begin
         sum_ff          <= sum_in;
         left_ff[m_idx]  <= ent_id_ff[0];
         right_ff[m_idx] <= ent_id_ff[1];
      end
      if (cmd.code_step) begin
         if (c0 < FIRST_MERGED) begin
            ldep_ff[c0[SB-1:0]]  <= kid_dep;
            lcode_ff[c0[SB-1:0]] <= code0;
         end else begin
            idep_ff[c0_int[MB-1:0]]  <= kid_dep;
            icode_ff[c0_int[MB-1:0]] <= code0;
         end
         if (c1 < FIRST_MERGED) begin
            ldep_ff[c1[SB-1:0]]  <= kid_dep;
            lcode_ff[c1[SB-1:0]] <= code1;
         end else begin
            idep_ff[c1_int[MB-1:0]]  <= kid_dep;
            icode_ff[c1_int[MB-1:0]] <= code1;
         end
      end
      if (cmd.emit) begin
         sym_ff  <= huff_pkg::INDEX_BITS'(e_idx);
         len_ff  <= ldep_ff[e_idx];
         bits_ff <= lcode_ff[e_idx];
         last_ff <= (e_idx == SB'(NS - 1));
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_symbol_index = sym_ff;
   assign rsp_code_length  = len_ff;
   assign rsp_code_bits    = bits_ff;
   assign rsp_last_code    = last_ff & strobe_ff;

   a_pop_pair: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> (ent_v_ff[0] && ent_v_ff[1]))
      else $error("merge with fewer than two live nodes");

   a_emit_beat: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_strobe)
      else $error("emit command lost its result beat");

   a_no_insert_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.insert_leaf || cmd.insert_node) |-> !ent_v_ff[NS - 1])
      else $error("insert into full node list");

endmodule
